// File: hw/rtl/icss_pkg.sv
// ----------------------------------------------------------------------------
// icss_pkg
// Shared widths, operation codes, status codes and controller state encoding
// of the indexed character sequence store.
// ----------------------------------------------------------------------------
package icss_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int FUNC_W  = 4;
	localparam int POS_W   = 7;
	localparam int VAL_W   = 8;
	localparam int TOTAL_W = 7;
	localparam int STAT_W  = 2;

	localparam logic [FUNC_W-1:0] FN_INSERT     = 4'd0;
	localparam logic [FUNC_W-1:0] FN_DELETE     = 4'd1;
	localparam logic [FUNC_W-1:0] FN_READ       = 4'd2;
	localparam logic [FUNC_W-1:0] FN_WRITE      = 4'd3;
	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd4;
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd5;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd6;
	localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd7;
	localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd8;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MOVE  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_PUT   = 5'b01000,
		ST_READ  = 5'b10000
	} state_t;

endpackage

// File: hw/rtl/indexed_char_sequence_store.sv
// ----------------------------------------------------------------------------
// indexed_char_sequence_store
// Bounded ordered list of bytes with insert, delete, read, write, push, pop
// and clear at a position, kept in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   An item (func, position, value) is accepted on a rising edge with start
//   high and busy low. Exactly one result follows: read_value, status and
//   entry_total are valid for the single cycle in which done is high. The
//   receiver cannot stall the block; results must be taken when shown.
//   Write, clear, failed operations, pops and deletes at the last position,
//   and the unused codes show done in the cycle after acceptance. A read
//   goes through the read state and an append through the put state first.
//   An insert at position p moves count-p entries, a delete at p moves
//   count-p-1 entries; one entry moves per cycle through the single read
//   and single write port of the memory, in the move state, then the drain
//   state follows, and an insert then writes its value in the put state.
//   busy rises at the accepting edge of an item that leaves the idle state
//   and stays high until the result is shown; a new item may be accepted
//   in the cycle in which done is high.
//   Reset clears the entry count and the controller; the memory content is
//   not cleared and is only ever read below the count.
// ----------------------------------------------------------------------------
module indexed_char_sequence_store
	import icss_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [FUNC_W-1:0]  func,
	input  logic [POS_W-1:0]   position,
	input  logic [VAL_W-1:0]   value,
	output logic               done,
	output logic [VAL_W-1:0]   read_value,
	output logic [STAT_W-1:0]  status,
	output logic [TOTAL_W-1:0] entry_total
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CW > POS_W) ? CW : POS_W;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   src_q;
	logic [CW-1:0]   moves_q;
	logic            ins_q;
	logic [IW-1:0]   op_pos_q;
	logic [VAL_W-1:0] op_val_q;
	logic            done_q;
	logic [VAL_W-1:0] read_value_q;
	status_t         status_q;

	logic [VAL_W-1:0] mem [CAPACITY];
	logic [VAL_W-1:0] rd_data_s1;
	logic            wr_pend_s1;
	logic [IW-1:0]   wr_addr_s1;

	logic            mem_we;
	logic [IW-1:0]   mem_waddr;
	logic [VAL_W-1:0] mem_wdata;
	logic [IW-1:0]   mem_raddr;

	logic            accept;
	logic [AW-1:0]   pos_ext;
	logic [AW-1:0]   cnt_ext;
	logic            is_ins;
	logic            is_del;
	logic [AW-1:0]   ins_pos;
	logic [AW-1:0]   del_pos;
	logic            cnt_full;
	logic            cnt_zero;
	logic            pos_bad;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign pos_ext = AW'(position);
	assign cnt_ext = AW'(count_q);
	assign cnt_full = (count_q == CW'(CAPACITY));
	assign cnt_zero = (count_q == '0);
	assign pos_bad  = (pos_ext >= cnt_ext);

	assign is_ins = (func == FN_INSERT) || (func == FN_PUSH_FRONT) || (func == FN_PUSH_BACK);
	assign is_del = (func == FN_DELETE) || (func == FN_POP_FRONT) || (func == FN_POP_BACK);

	always_comb begin
		priority if (func == FN_PUSH_FRONT) begin
			ins_pos = '0;
		end else if (func == FN_PUSH_BACK) begin
			ins_pos = cnt_ext;
		end else begin
			ins_pos = pos_ext;
		end
		priority if (func == FN_POP_FRONT) begin
			del_pos = '0;
		end else if (func == FN_POP_BACK) begin
			del_pos = cnt_ext - AW'(1);
		end else begin
			del_pos = pos_ext;
		end
	end

	// Write port: a pending move wins; the controller never overlaps it with
	// the final insert write or a direct write.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_addr_s1;
		mem_wdata = rd_data_s1;
		priority if (wr_pend_s1) begin
			mem_we = 1'b1;
		end else if (state_q == ST_PUT) begin
			mem_we    = 1'b1;
			mem_waddr = op_pos_q;
			mem_wdata = op_val_q;
		end else if (accept && (func == FN_WRITE) && !pos_bad) begin
			mem_we    = 1'b1;
			mem_waddr = pos_ext[IW-1:0];
			mem_wdata = value;
		end else begin
			mem_we = 1'b0;
		end
	end

	assign mem_raddr = (state_q == ST_MOVE) ? src_q : pos_ext[IW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_s1 <= 1'b0;
		end else begin
			wr_pend_s1 <= (state_q == ST_MOVE);
		end
	end

	// Insert moves toward the back, delete toward the front.
	always_ff @(posedge clk) begin
		wr_addr_s1 <= ins_q ? (src_q + IW'(1)) : (src_q - IW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			done_q       <= 1'b0;
			status_q     <= STAT_OK;
			read_value_q <= '0;
			src_q        <= '0;
			moves_q      <= '0;
			ins_q        <= 1'b0;
			op_pos_q     <= '0;
			op_val_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						read_value_q <= '0;
						status_q     <= STAT_OK;
						op_val_q     <= value;
						priority if (is_ins) begin
							ins_q    <= 1'b1;
							op_pos_q <= ins_pos[IW-1:0];
							priority if (ins_pos > cnt_ext) begin
								status_q <= STAT_RANGE;
								done_q   <= 1'b1;
							end else if (cnt_full) begin
								status_q <= STAT_FULL;
								done_q   <= 1'b1;
							end else if (ins_pos == cnt_ext) begin
								state_q <= ST_PUT;
							end else begin
								src_q   <= IW'(cnt_ext - AW'(1));
								moves_q <= CW'(cnt_ext - ins_pos);
								state_q <= ST_MOVE;
							end
						end else if (is_del) begin
							ins_q <= 1'b0;
							priority if (cnt_zero && (func != FN_DELETE)) begin
								status_q <= STAT_EMPTY;
								done_q   <= 1'b1;
							end else if (del_pos >= cnt_ext) begin
								status_q <= STAT_RANGE;
								done_q   <= 1'b1;
							end else if (del_pos == cnt_ext - AW'(1)) begin
								count_q <= count_q - CW'(1);
								done_q  <= 1'b1;
							end else begin
								src_q   <= IW'(del_pos + AW'(1));
								moves_q <= CW'(cnt_ext - del_pos - AW'(1));
								state_q <= ST_MOVE;
							end
						end else if (func == FN_READ) begin
							if (pos_bad) begin
								status_q <= STAT_RANGE;
								done_q   <= 1'b1;
							end else begin
								state_q <= ST_READ;
							end
						end else if (func == FN_WRITE) begin
							status_q <= pos_bad ? STAT_RANGE : STAT_OK;
							done_q   <= 1'b1;
						end else if (func == FN_CLEAR) begin
							count_q <= '0;
							done_q  <= 1'b1;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_MOVE: begin
					moves_q <= moves_q - CW'(1);
					src_q   <= ins_q ? (src_q - IW'(1)) : (src_q + IW'(1));
					if (moves_q == CW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (ins_q) begin
						state_q <= ST_PUT;
					end else begin
						count_q <= count_q - CW'(1);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_PUT: begin
					count_q <= count_q + CW'(1);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					read_value_q <= rd_data_s1;
					done_q       <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign entry_total = cnt_ext[TOTAL_W-1:0];

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state is not one-hot");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (done_q && ((count_q == $past(count_q) + CW'(1))
			|| (count_q == $past(count_q) - CW'(1)) || (count_q == '0))))
		else $error("entry count changed without a result or by more than one");

	a_move_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_s1 |-> ((state_q == ST_MOVE) || (state_q == ST_DRAIN)))
		else $error("pending move write outside a move sequence");

	a_busy_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MOVE) || (state_q == ST_DRAIN)) |-> !done_q || $past(state_q == ST_IDLE))
		else $error("result shown in the middle of a move sequence");

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed character sequence store. Items are
// driven through the start/busy handshake with random idle gaps, a shadow
// copy of the list predicts every result, and each done strobe is compared
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import icss_pkg::*;

	localparam int CAPACITY     = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1600;
	localparam int DRAIN_CYCLES = CAPACITY + 8;
	localparam longint RUN_LIMIT = 64'd12_000_000;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [POS_W-1:0]  position;
		logic [VAL_W-1:0]  value;
	} list_cmd_t;

	typedef struct packed {
		logic [VAL_W-1:0]   read_value;
		status_t            status;
		logic [TOTAL_W-1:0] entry_total;
	} list_reply_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [FUNC_W-1:0]  func = '0;
	logic [POS_W-1:0]   position = '0;
	logic [VAL_W-1:0]   value = '0;
	logic               busy;
	logic               done;
	logic [VAL_W-1:0]   read_value;
	logic [STAT_W-1:0]  status;
	logic [TOTAL_W-1:0] entry_total;

	// Shadow copy of the list as it stands after every accepted item.
	logic [VAL_W-1:0] shadow_bytes [CAPACITY];
	int               shadow_count = 0;
	int               peak_count = 0;

	list_reply_t pending_replies [$];
	int          fail_count = 0;
	int          replies_checked = 0;
	int          op_seen [16];
	int          status_seen [4];
	int          random_issued = 0;
	bit          burst_mode = 1'b0;

	indexed_char_sequence_store #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.position    (position),
		.value       (value),
		.done        (done),
		.read_value  (read_value),
		.status      (status),
		.entry_total (entry_total)
	);

	always #6 clk = ~clk;

	function automatic status_t place_byte(int p, logic [VAL_W-1:0] v);
		if (p > shadow_count)
			return STAT_RANGE;
		if (shadow_count >= CAPACITY)
			return STAT_FULL;
		for (int i = shadow_count; i > p; i--)
			shadow_bytes[i] = shadow_bytes[i-1];
		shadow_bytes[p] = v;
		shadow_count++;
		return STAT_OK;
	endfunction

	function automatic void remove_byte(int p);
		for (int i = p; i < shadow_count - 1; i++)
			shadow_bytes[i] = shadow_bytes[i+1];
		shadow_count--;
	endfunction

	function automatic list_reply_t apply_list_op(list_cmd_t c);
		list_reply_t r;
		int          p;
		p = int'(c.position);
		r.read_value = '0;
		r.status = STAT_OK;
		case (c.func)
			FN_INSERT: r.status = place_byte(p, c.value);
			FN_DELETE: begin
				if (p >= shadow_count)
					r.status = STAT_RANGE;
				else
					remove_byte(p);
			end
			FN_READ: begin
				if (p >= shadow_count)
					r.status = STAT_RANGE;
				else
					r.read_value = shadow_bytes[p];
			end
			FN_WRITE: begin
				if (p >= shadow_count)
					r.status = STAT_RANGE;
				else
					shadow_bytes[p] = c.value;
			end
			FN_PUSH_FRONT: r.status = place_byte(0, c.value);
			FN_PUSH_BACK:  r.status = place_byte(shadow_count, c.value);
			FN_POP_FRONT: begin
				if (shadow_count == 0)
					r.status = STAT_EMPTY;
				else
					remove_byte(0);
			end
			FN_POP_BACK: begin
				if (shadow_count == 0)
					r.status = STAT_EMPTY;
				else
					remove_byte(shadow_count - 1);
			end
			FN_CLEAR: shadow_count = 0;
			default: ;
		endcase
		r.entry_total = shadow_count[TOTAL_W-1:0];
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] pick_byte();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return VAL_W'($urandom_range(0, (1 << VAL_W) - 1));
	endfunction

	// Mostly legal positions for the current length, the rest anywhere in the field.
	function automatic logic [POS_W-1:0] pick_position(logic [FUNC_W-1:0] f);
		int span;
		span = (f == FN_INSERT) ? shadow_count + 1 : shadow_count;
		if (span > 0 && $urandom_range(0, 99) < 85)
			return POS_W'($urandom_range(0, span - 1));
		return POS_W'($urandom_range(0, (1 << POS_W) - 1));
	endfunction

	task automatic send_list_op(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
			logic [VAL_W-1:0] v);
		list_cmd_t c;
		int        gap;
		c.func = f;
		c.position = p;
		c.value = v;
		func <= f;
		position <= p;
		value <= v;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_replies.push_back(apply_list_op(c));
		op_seen[f]++;
		if (shadow_count > peak_count)
			peak_count = shadow_count;
		gap = burst_mode ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Results cannot be held off, so every done strobe is checked at the edge
	// that ends it.
	always @(posedge clk) begin
		list_reply_t want;
		if (done === 1'b1) begin
			replies_checked++;
			status_seen[status]++;
			if (pending_replies.size() == 0) begin
				$error("result with no item outstanding: read_value %0d status %0d total %0d",
					read_value, status, entry_total);
				fail_count++;
			end else begin
				want = pending_replies.pop_front();
				if (read_value !== want.read_value) begin
					$error("read_value: expected %0d, actual %0d", want.read_value, read_value);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					fail_count++;
				end
				if (entry_total !== want.entry_total) begin
					$error("entry_total: expected %0d, actual %0d", want.entry_total,
						entry_total);
					fail_count++;
				end
			end
		end
	end

	task automatic test_empty_store();
		send_list_op(FN_POP_FRONT, '0, '0);
		send_list_op(FN_POP_BACK, '0, '0);
		send_list_op(FN_DELETE, '0, '0);
		send_list_op(FN_READ, '0, '0);
		send_list_op(FN_WRITE, '0, '1);
		send_list_op(FN_INSERT, 7'd1, 8'h55);
		send_list_op(FN_READ, '1, '0);
		send_list_op(4'd15, '1, '1);
		send_list_op(FN_CLEAR, '0, '0);
	endtask

	task automatic test_small_list_ops();
		send_list_op(FN_INSERT, '0, 8'h00);
		send_list_op(FN_PUSH_BACK, '0, 8'hFF);
		send_list_op(FN_PUSH_FRONT, '0, 8'h80);
		send_list_op(FN_INSERT, 7'd1, 8'h01);
		send_list_op(FN_INSERT, 7'd4, 8'h7F);
		send_list_op(FN_READ, 7'd0, '0);
		send_list_op(FN_READ, 7'd4, '0);
		send_list_op(FN_WRITE, 7'd2, 8'hAA);
		send_list_op(FN_READ, 7'd2, '0);
		send_list_op(FN_DELETE, 7'd4, '0);
		send_list_op(FN_DELETE, 7'd1, '0);
		send_list_op(FN_POP_FRONT, '0, '0);
		send_list_op(FN_POP_BACK, '0, '0);
		send_list_op(FN_READ, 7'd64, '0);
		send_list_op(4'd9, 7'd3, 8'h3C);
		send_list_op(FN_CLEAR, '0, '0);
	endtask

	task automatic test_full_store();
		logic [FUNC_W-1:0] f;
		while (shadow_count < CAPACITY) begin
			case ($urandom_range(0, 2))
				0: f = FN_INSERT;
				1: f = FN_PUSH_FRONT;
				default: f = FN_PUSH_BACK;
			endcase
			send_list_op(f, POS_W'($urandom_range(0, shadow_count)), pick_byte());
		end
		send_list_op(FN_PUSH_FRONT, '0, 8'h11);
		send_list_op(FN_PUSH_BACK, '0, 8'h22);
		send_list_op(FN_INSERT, '0, 8'h33);
		send_list_op(FN_INSERT, POS_W'(CAPACITY), 8'h44);
		// The position check wins over the full check.
		send_list_op(FN_INSERT, POS_W'(CAPACITY + 1), 8'h55);
		send_list_op(FN_READ, POS_W'(CAPACITY - 1), '0);
		send_list_op(FN_READ, POS_W'(CAPACITY), '0);
		send_list_op(FN_WRITE, POS_W'(CAPACITY - 1), '1);
		send_list_op(FN_READ, POS_W'(CAPACITY - 1), '0);
		send_list_op(FN_DELETE, '0, '0);
		send_list_op(FN_INSERT, '0, 8'h5A);
		send_list_op(FN_READ, '0, '0);
		send_list_op(FN_DELETE, POS_W'(CAPACITY - 1), '0);
		send_list_op(FN_POP_BACK, '0, '0);
		send_list_op(FN_POP_FRONT, '0, '0);
		send_list_op(FN_DELETE, '1, '0);
		send_list_op(FN_CLEAR, '0, '0);
		send_list_op(FN_READ, '0, '0);
	endtask

	task automatic random_list_op(int grow_pct);
		logic [FUNC_W-1:0] f;
		int                roll;
		roll = $urandom_range(0, 199);
		if (roll < 12) begin
			f = FUNC_W'($urandom_range(0, 15));
		end else if (roll < 13) begin
			f = FN_CLEAR;
		end else if ($urandom_range(0, 99) < grow_pct) begin
			case ($urandom_range(0, 2))
				0: f = FN_INSERT;
				1: f = FN_PUSH_FRONT;
				default: f = FN_PUSH_BACK;
			endcase
		end else begin
			case ($urandom_range(0, 5))
				0: f = FN_DELETE;
				1: f = FN_READ;
				2: f = FN_WRITE;
				3: f = FN_POP_FRONT;
				4: f = FN_POP_BACK;
				default: f = FN_READ;
			endcase
		end
		if (f <= FN_CLEAR)
			random_issued++;
		send_list_op(f, pick_position(f), pick_byte());
	endtask

	// Phases lean toward growth, shrinkage or balance so that the list spends
	// time both full and empty; some phases run without idle gaps.
	task automatic test_random_phases();
		int phase_len;
		int grow_pct;
		while (random_issued < RANDOM_ITEMS) begin
			phase_len = $urandom_range(40, 160);
			case ($urandom_range(0, 2))
				0: grow_pct = 15;
				1: grow_pct = 50;
				default: grow_pct = 85;
			endcase
			burst_mode = ($urandom_range(0, 3) == 0);
			repeat (phase_len) random_list_op(grow_pct);
		end
		burst_mode = 1'b0;
	endtask

	initial begin
		int unused_ops;
		unused_ops = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_small_list_ops();
		test_full_store();
		test_random_phases();
		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		for (int i = 9; i < 16; i++)
			unused_ops += op_seen[i];
		$write("Run covered %0d inserts, %0d deletes, %0d reads, %0d writes, ",
			op_seen[FN_INSERT], op_seen[FN_DELETE], op_seen[FN_READ], op_seen[FN_WRITE]);
		$display("%0d pushes, %0d pops, %0d clears and %0d unused codes.",
			op_seen[FN_PUSH_FRONT] + op_seen[FN_PUSH_BACK],
			op_seen[FN_POP_FRONT] + op_seen[FN_POP_BACK], op_seen[FN_CLEAR], unused_ops);
		$write("Checked %0d results (ok %0d, range %0d, full %0d, empty %0d); ",
			replies_checked, status_seen[STAT_OK], status_seen[STAT_RANGE],
			status_seen[STAT_FULL], status_seen[STAT_EMPTY]);
		$display("list peaked at %0d of %0d.", peak_count, CAPACITY);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("Timeout with %0d results still outstanding.", pending_replies.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
